FILE: rtl/vfsp_pkg.sv
// Shared constants and types for the faux vertex shading pipeline
package vfsp_pkg;

   localparam int FIELD_W    = 16;
   localparam int CHAN_NUM   = 4;
   localparam int NUM_STAGES = 7;
   localparam int NMAG_W     = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam int COLOR_FRAC_BITS_DEF  = 12;
   localparam int NORMAL_FRAC_BITS_DEF = 14;

   localparam logic [FIELD_W-1:0] INV_SQRT3_Q16 = 16'd37837;
   localparam logic [FIELD_W-1:0] REVERSE_Q16   = 16'd52429;
   localparam logic [7:0]         SAT_MAX       = 8'hFF;

   localparam logic [CSR_IDX_W-1:0] CSR_LITE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DARK  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MULT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MULEN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORGEN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHDEN = 3'd5;

   localparam logic [CSR_DATA_W-1:0] LITE_RST = 64'h1000_1000_1000_1000;
   localparam logic [CSR_DATA_W-1:0] DARK_RST = 64'h0000_0000_0000_1000;
   localparam logic [CSR_DATA_W-1:0] MULT_RST = 64'h1000_1000_1000_1000;

   typedef logic [NUM_STAGES-1:0] stage_en_type;

   typedef struct packed {
      stage_en_type ld;
      logic         shade;
      logic         orig;
      logic         mult;
   } ctl_type;

endpackage

FILE: rtl/vertex_faux_shade_pack_top.sv
// Faux vertex shading top: stage control, control registers, ARGB8888 output register
//
// Channel  Handshake              Payload
// req      req_valid / req_stall  normal x/y/z (Q1.14), original RGBA (Q4.12), last_in_mesh
// rsp      rsp_valid / rsp_stall  packed_argb, end_of_mesh
// csr      csr_wr_en              csr_index, csr_wr_data (write only)
//
// One request per cycle while req_stall is low; each of the seven stages holds at most one multiply per channel.
// rsp_valid is the last stage's valid bit; it rises when an accepted request reaches that stage.
// Reset clears all stage valid bits and loads the register defaults.
// Empty stages keep filling while rsp is stalled; req_stall rises only when all stages hold data.
module vertex_faux_shade_pack_top #(
   parameter int COLOR_FRAC_BITS  = vfsp_pkg::COLOR_FRAC_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = vfsp_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [vfsp_pkg::FIELD_W-1:0]  req_normal_x,
   input  logic signed [vfsp_pkg::FIELD_W-1:0]  req_normal_y,
   input  logic signed [vfsp_pkg::FIELD_W-1:0]  req_normal_z,
   input  logic [vfsp_pkg::FIELD_W-1:0]         req_orig_red,
   input  logic [vfsp_pkg::FIELD_W-1:0]         req_orig_green,
   input  logic [vfsp_pkg::FIELD_W-1:0]         req_orig_blue,
   input  logic [vfsp_pkg::FIELD_W-1:0]         req_orig_alpha,
   input  logic                                 req_last_in_mesh,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [31:0]                          rsp_packed_argb,
   output logic                                 rsp_end_of_mesh,
   input  logic                                 csr_wr_en,
   input  logic [vfsp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vfsp_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import vfsp_pkg::*;

   localparam int S_W = NMAG_W + FIELD_W - NORMAL_FRAC_BITS;

   logic [CSR_DATA_W-1:0] lite_ff, dark_ff, mult_ff;
   logic                  mult_en_ff, orig_en_ff, shade_en_ff;

   stage_en_type v_ff, v_in, rdy, v_prev, ld;
   ctl_type      ctl;

   logic [S_W-1:0]     scale;
   logic [FIELD_W-1:0] orig_ch [CHAN_NUM];
   logic [7:0]         ch8 [CHAN_NUM];
   logic [NUM_STAGES-2:0] last_ff;
   logic [31:0]        packed_ff, packed_in;
   logic               eom_ff;

   // request path control
   always_comb begin
      rdy[NUM_STAGES-1] = !v_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES-2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      v_prev = {v_ff[NUM_STAGES-2:0], req_valid};
      ld     = rdy & v_prev;
      v_in   = (rdy & v_prev) | (~rdy & v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !rdy[0];
   assign ctl       = {ld, shade_en_ff, orig_en_ff, mult_en_ff};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lite_ff     <= LITE_RST;
         dark_ff     <= DARK_RST;
         mult_ff     <= MULT_RST;
         mult_en_ff  <= 1'b0;
         orig_en_ff  <= 1'b0;
         shade_en_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LITE:  lite_ff     <= csr_wr_data;
            CSR_DARK:  dark_ff     <= csr_wr_data;
            CSR_MULT:  mult_ff     <= csr_wr_data;
            CSR_MULEN: mult_en_ff  <= csr_wr_data[0];
            CSR_ORGEN: orig_en_ff  <= csr_wr_data[0];
            CSR_SHDEN: shade_en_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   vfsp_scale #(
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_scale (
      .clock    (clock),
      .ld       (ld),
      .normal_x (req_normal_x),
      .normal_y (req_normal_y),
      .normal_z (req_normal_z),
      .scale    (scale)
   );

   assign orig_ch[0] = req_orig_red;
   assign orig_ch[1] = req_orig_green;
   assign orig_ch[2] = req_orig_blue;
   assign orig_ch[3] = req_orig_alpha;

   for (genvar i = 0; i < CHAN_NUM; i++) begin : g_chan
      vfsp_chan #(
         .COLOR_FRAC_BITS  (COLOR_FRAC_BITS),
         .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
      ) u_chan (
         .clock   (clock),
         .ctl     (ctl),
         .lite    (lite_ff[CSR_DATA_W-1-FIELD_W*i -: FIELD_W]),
         .dark    (dark_ff[CSR_DATA_W-1-FIELD_W*i -: FIELD_W]),
         .tint    (mult_ff[CSR_DATA_W-1-FIELD_W*i -: FIELD_W]),
         .orig_in (orig_ch[i]),
         .scale   (scale),
         .ch8     (ch8[i])
      );
   end

   // ARGB: alpha, red, green, blue from high bits
   assign packed_in = {ch8[3], ch8[0], ch8[1], ch8[2]};

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         last_ff[0] <= req_last_in_mesh;
      end
      for (int k = 1; k < NUM_STAGES-1; k++) begin
         if (ld[k]) begin
            last_ff[k] <= last_ff[k-1];
         end
      end
      if (ld[NUM_STAGES-1]) begin
         packed_ff <= packed_in;
         eom_ff    <= last_ff[NUM_STAGES-2];
      end
   end

   assign rsp_valid       = v_ff[NUM_STAGES-1];
   assign rsp_packed_argb = packed_ff;
   assign rsp_end_of_mesh = eom_ff;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v_ff[0])
      else $error("accepted request did not enter first stage");

   a_bubble_no_stall: assert property (@(posedge clock) disable iff (reset)
      !(&v_ff) |-> !req_stall)
      else $error("req stalled while a stage is empty");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&v_ff) && rsp_stall) |-> req_stall)
      else $error("full stalled pipeline accepted a request");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (v_ff[NUM_STAGES-1] && $stable(packed_ff)))
      else $error("stalled response changed");

endmodule

FILE: rtl/vfsp_scale.sv
// Light scale stages: normal sum magnitude, 1/sqrt(3) scale, back-face 0.8 scale
module vfsp_scale #(
   parameter int NORMAL_FRAC_BITS = vfsp_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  logic                                        clock,
   input  vfsp_pkg::stage_en_type                      ld,
   input  logic signed [vfsp_pkg::FIELD_W-1:0]         normal_x,
   input  logic signed [vfsp_pkg::FIELD_W-1:0]         normal_y,
   input  logic signed [vfsp_pkg::FIELD_W-1:0]         normal_z,
   output logic [vfsp_pkg::NMAG_W+vfsp_pkg::FIELD_W-NORMAL_FRAC_BITS-1:0] scale
);
   import vfsp_pkg::*;

   localparam int S_W = NMAG_W + FIELD_W - NORMAL_FRAC_BITS;
   localparam int P_W = NMAG_W + FIELD_W;

   logic signed [NMAG_W:0] sum;
   logic [NMAG_W:0]        sum_abs;
   logic [P_W-1:0]         prod;
   logic [S_W+FIELD_W-1:0] rev;

   logic [NMAG_W-1:0] mag1_ff, mag1_in;
   logic              neg1_ff, neg2_ff;
   logic [S_W-1:0]    mag2_ff, mag2_in;
   logic [S_W-1:0]    s3_ff, s3_in;

   always_comb begin
      sum     = {{2{normal_x[FIELD_W-1]}}, normal_x} + {{2{normal_y[FIELD_W-1]}}, normal_y}
              + {{2{normal_z[FIELD_W-1]}}, normal_z};
      sum_abs = sum[NMAG_W] ? ((NMAG_W+1)'(0) - sum) : sum;
      mag1_in = sum_abs[NMAG_W-1:0];
      prod    = mag1_ff * INV_SQRT3_Q16;
      mag2_in = prod[P_W-1:NORMAL_FRAC_BITS];
      rev     = mag2_ff * REVERSE_Q16;
      s3_in   = neg2_ff ? rev[S_W+FIELD_W-1:FIELD_W] : mag2_ff;
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         mag1_ff <= mag1_in;
         neg1_ff <= sum[NMAG_W];
      end
      if (ld[1]) begin
         mag2_ff <= mag2_in;
         neg2_ff <= neg1_ff;
      end
      if (ld[2]) begin
         s3_ff <= s3_in;
      end
   end

   assign scale = s3_ff;

endmodule

FILE: rtl/vfsp_chan.sv
// One color channel: lite/dark blend, original and tint multiplies, 8-bit saturation
module vfsp_chan #(
   parameter int COLOR_FRAC_BITS  = vfsp_pkg::COLOR_FRAC_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = vfsp_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  vfsp_pkg::ctl_type                   ctl,
   input  logic [vfsp_pkg::FIELD_W-1:0]        lite,
   input  logic [vfsp_pkg::FIELD_W-1:0]        dark,
   input  logic [vfsp_pkg::FIELD_W-1:0]        tint,
   input  logic [vfsp_pkg::FIELD_W-1:0]        orig_in,
   input  logic [vfsp_pkg::NMAG_W+vfsp_pkg::FIELD_W-NORMAL_FRAC_BITS-1:0] scale,
   output logic [7:0]                          ch8
);
   import vfsp_pkg::*;

   localparam int S_W   = NMAG_W + FIELD_W - NORMAL_FRAC_BITS;
   localparam int C0_W  = S_W + 18;
   localparam int CP_W  = C0_W - 1;
   localparam int EXT_W = FIELD_W - COLOR_FRAC_BITS;
   localparam int C1_W  = CP_W + EXT_W;
   localparam int C2_W  = C1_W + EXT_W;
   localparam int ONE_B = COLOR_FRAC_BITS + FIELD_W;
   localparam int ODEP  = NUM_STAGES - 1;

   logic [FIELD_W-1:0] o_ff [ODEP];

   logic signed [FIELD_W:0] diff;
   logic signed [S_W:0]     s_sg;
   logic signed [C0_W-1:0]  prod_sg;
   logic signed [C0_W-1:0]  base;
   logic [CP_W-1:0]         cp;
   logic [CP_W+FIELD_W-1:0] m5;
   logic [C1_W+FIELD_W-1:0] m6;
   logic [ONE_B-1:0]        wl;
   logic [ONE_B+7:0]        w255;
   logic [COLOR_FRAC_BITS-1:0] pl;
   logic [COLOR_FRAC_BITS+7:0] p255;

   logic signed [C0_W-1:0] c0_ff, c0_in;
   logic [C1_W-1:0]        c1_ff, c1_in;
   logic [C2_W-1:0]        c2_ff, c2_in;

   always_comb begin
      diff    = $signed({1'b0, lite}) - $signed({1'b0, dark});
      s_sg    = $signed({1'b0, scale});
      prod_sg = diff * s_sg;
      base    = $signed({{(C0_W-32){1'b0}}, dark, 16'h0000});
      c0_in   = prod_sg + base;

      cp    = c0_ff[C0_W-1] ? '0 : c0_ff[CP_W-1:0];
      m5    = cp * o_ff[3];
      c1_in = ctl.orig ? m5[CP_W+FIELD_W-1:COLOR_FRAC_BITS] : {{EXT_W{1'b0}}, cp};

      m6    = c1_ff * tint;
      c2_in = ctl.mult ? m6[C1_W+FIELD_W-1:COLOR_FRAC_BITS] : {{EXT_W{1'b0}}, c1_ff};

      wl   = c2_ff[ONE_B-1:0];
      w255 = {wl, 8'h00} - {8'h00, wl};
      pl   = o_ff[ODEP-1][COLOR_FRAC_BITS-1:0];
      p255 = {pl, 8'h00} - {8'h00, pl};

      if (ctl.shade) begin
         ch8 = (|c2_ff[C2_W-1:ONE_B]) ? SAT_MAX : w255[ONE_B+7:ONE_B];
      end else begin
         ch8 = (|o_ff[ODEP-1][FIELD_W-1:COLOR_FRAC_BITS]) ? SAT_MAX
               : p255[COLOR_FRAC_BITS+7:COLOR_FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld[0]) begin
         o_ff[0] <= orig_in;
      end
      for (int k = 1; k < ODEP; k++) begin
         if (ctl.ld[k]) begin
            o_ff[k] <= o_ff[k-1];
         end
      end
      if (ctl.ld[3]) begin
         c0_ff <= c0_in;
      end
      if (ctl.ld[4]) begin
         c1_ff <= c1_in;
      end
      if (ctl.ld[5]) begin
         c2_ff <= c2_in;
      end
   end

endmodule
